[src/s256sh_pkg.sv]
// ----------------------------------------------------------------------------
// s256sh_pkg
// Types, round constants and initial hash values shared by the SHA-256
// stream hasher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s256sh_pkg;

  // One input item: a message byte and its flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       msg_last;
  } in_item_t;

  // One result item: a digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        word_last;
  } out_item_t;

  // Source of a byte written into the block buffer.
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO
  } byte_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Where the controller goes once a compression has finished.
  typedef enum logic [1:0] {
    POST_IDLE,
    POST_MARK,
    POST_ZERO,
    POST_OUT
  } post_t;

  typedef struct packed {
    logic      byte_wr;
    byte_sel_t byte_sel;
    logic      len_wr;
    logic      work_load;
    logic      round_step;
    logic      chain_update;
    logic      out_step;
    logic      msg_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_at_pad_last;
    logic fill_at_block_last;
    logic round_last;
    logic out_last;
  } dp_status_t;

  localparam logic [5:0]  FILL_PAD_LAST   = 6'd55;
  localparam logic [5:0]  FILL_BLOCK_LAST = 6'd63;
  localparam logic [5:0]  ROUND_LAST      = 6'd63;
  localparam logic [2:0]  WORD_LAST_IDX   = 3'd7;
  localparam logic [7:0]  PAD_MARK        = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE   = 64'd8;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

[src/s256sh_datapath.sv]
// ----------------------------------------------------------------------------
// s256sh_datapath
// Block buffer with message schedule, round registers, chaining hash,
// byte and length counters, and the digest word select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s256sh_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire s256sh_pkg::dp_cmd_t    cmd,
  input  wire logic [7:0]             data_byte,
  output s256sh_pkg::dp_status_t      status,
  output s256sh_pkg::out_item_t       out_item
);

  logic [31:0] block_words [16];
  logic [31:0] work_regs [8];
  logic [31:0] chain_hash [8];
  logic [5:0]  fill_count;
  logic [63:0] total_bits;
  logic [5:0]  round_idx;
  logic [2:0]  out_idx;

  logic [7:0]  byte_val;
  logic [3:0]  word_sel;
  logic [1:0]  lane_sel;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  always_comb begin
    case (cmd.byte_sel)
      s256sh_pkg::BSEL_DATA: byte_val = data_byte;
      s256sh_pkg::BSEL_MARK: byte_val = s256sh_pkg::PAD_MARK;
      s256sh_pkg::BSEL_ZERO: byte_val = 8'h00;
      default:               byte_val = 8'h00;
    endcase
  end

  // Bytes are packed big-endian: the first byte of a word is its top byte.
  assign word_sel = fill_count[5:2];
  assign lane_sel = ~fill_count[1:0];

  // The buffer doubles as the sixteen-word schedule window; word 0 is the
  // current round's schedule word.
  assign sched_new = ssig1(block_words[14]) + block_words[9]
                   + ssig0(block_words[1]) + block_words[0];

  assign t1 = work_regs[7] + bsig1(work_regs[4])
            + ((work_regs[4] & work_regs[5]) ^ (~work_regs[4] & work_regs[6]))
            + s256sh_pkg::ROUND_K[round_idx] + block_words[0];
  assign t2 = bsig0(work_regs[0])
            + ((work_regs[0] & work_regs[1]) ^ (work_regs[0] & work_regs[2])
               ^ (work_regs[1] & work_regs[2]));

  always_ff @(posedge clk) begin
    if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        block_words[i] <= block_words[i + 1];
      end
      block_words[15] <= sched_new;
    end else if (cmd.len_wr) begin
      block_words[14] <= total_bits[63:32];
      block_words[15] <= total_bits[31:0];
    end else if (cmd.byte_wr) begin
      block_words[word_sel][{lane_sel, 3'b000} +: 8] <= byte_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.work_load) begin
      for (int i = 0; i < 8; i++) begin
        work_regs[i] <= chain_hash[i];
      end
    end else if (cmd.round_step) begin
      work_regs[7] <= work_regs[6];
      work_regs[6] <= work_regs[5];
      work_regs[5] <= work_regs[4];
      work_regs[4] <= work_regs[3] + t1;
      work_regs[3] <= work_regs[2];
      work_regs[2] <= work_regs[1];
      work_regs[1] <= work_regs[0];
      work_regs[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_clear) begin
      for (int i = 0; i < 8; i++) begin
        chain_hash[i] <= s256sh_pkg::INIT_HASH[i];
      end
      fill_count <= '0;
      total_bits <= '0;
    end else begin
      if (cmd.chain_update) begin
        for (int i = 0; i < 8; i++) begin
          chain_hash[i] <= chain_hash[i] + work_regs[i];
        end
      end
      if (cmd.byte_wr) begin
        fill_count <= fill_count + 6'd1;
      end
      if (cmd.byte_wr && cmd.byte_sel == s256sh_pkg::BSEL_DATA) begin
        total_bits <= total_bits + s256sh_pkg::BITS_PER_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_idx <= '0;
      out_idx   <= '0;
    end else begin
      if (cmd.work_load) begin
        round_idx <= '0;
      end else if (cmd.round_step) begin
        round_idx <= round_idx + 6'd1;
      end
      if (cmd.out_step) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  assign status.fill_at_pad_last   = (fill_count == s256sh_pkg::FILL_PAD_LAST);
  assign status.fill_at_block_last = (fill_count == s256sh_pkg::FILL_BLOCK_LAST);
  assign status.round_last         = (round_idx == s256sh_pkg::ROUND_LAST);
  assign status.out_last           = (out_idx == s256sh_pkg::WORD_LAST_IDX);

  assign out_item.digest_word = chain_hash[out_idx];
  assign out_item.word_index  = out_idx;
  assign out_item.word_last   = (out_idx == s256sh_pkg::WORD_LAST_IDX);

endmodule

`default_nettype wire

[src/s256sh_ctrl.sv]
// ----------------------------------------------------------------------------
// s256sh_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s256sh_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   msg_valid,
  input  wire s256sh_pkg::in_item_t   msg_item,
  input  wire logic                   digest_ready,
  input  wire s256sh_pkg::dp_status_t status,
  output logic                        msg_ready,
  output logic                        digest_valid,
  output s256sh_pkg::dp_cmd_t         cmd
);

  s256sh_pkg::state_t state;
  s256sh_pkg::state_t state_next;
  s256sh_pkg::post_t  post;
  s256sh_pkg::post_t  post_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s256sh_pkg::ST_IDLE;
      post  <= s256sh_pkg::POST_IDLE;
    end else begin
      state <= state_next;
      post  <= post_next;
    end
  end

  always_comb begin
    state_next   = state;
    post_next    = post;
    msg_ready    = 1'b0;
    digest_valid = 1'b0;
    cmd          = '0;
    cmd.byte_sel = s256sh_pkg::BSEL_DATA;

    case (state)
      s256sh_pkg::ST_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          if (msg_item.byte_valid) begin
            cmd.byte_wr = 1'b1;
            if (status.fill_at_block_last) begin
              // This byte completes the block, so compress before any padding.
              post_next  = msg_item.msg_last ? s256sh_pkg::POST_MARK
                                             : s256sh_pkg::POST_IDLE;
              state_next = s256sh_pkg::ST_LOAD;
            end else if (msg_item.msg_last) begin
              state_next = s256sh_pkg::ST_MARK;
            end
          end else if (msg_item.msg_last) begin
            state_next = s256sh_pkg::ST_MARK;
          end
        end
      end

      s256sh_pkg::ST_MARK, s256sh_pkg::ST_ZERO: begin
        cmd.byte_wr  = 1'b1;
        cmd.byte_sel = (state == s256sh_pkg::ST_MARK) ? s256sh_pkg::BSEL_MARK
                                                      : s256sh_pkg::BSEL_ZERO;
        if (status.fill_at_block_last) begin
          // No room for the length: finish this block, then a zero block.
          post_next  = s256sh_pkg::POST_ZERO;
          state_next = s256sh_pkg::ST_LOAD;
        end else if (status.fill_at_pad_last) begin
          state_next = s256sh_pkg::ST_LEN;
        end else begin
          state_next = s256sh_pkg::ST_ZERO;
        end
      end

      s256sh_pkg::ST_LEN: begin
        cmd.len_wr = 1'b1;
        post_next  = s256sh_pkg::POST_OUT;
        state_next = s256sh_pkg::ST_LOAD;
      end

      s256sh_pkg::ST_LOAD: begin
        cmd.work_load = 1'b1;
        state_next    = s256sh_pkg::ST_ROUND;
      end

      s256sh_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_next = s256sh_pkg::ST_UPDATE;
        end
      end

      s256sh_pkg::ST_UPDATE: begin
        cmd.chain_update = 1'b1;
        case (post)
          s256sh_pkg::POST_IDLE: state_next = s256sh_pkg::ST_IDLE;
          s256sh_pkg::POST_MARK: state_next = s256sh_pkg::ST_MARK;
          s256sh_pkg::POST_ZERO: state_next = s256sh_pkg::ST_ZERO;
          s256sh_pkg::POST_OUT:  state_next = s256sh_pkg::ST_OUT;
          default:               state_next = s256sh_pkg::ST_IDLE;
        endcase
      end

      s256sh_pkg::ST_OUT: begin
        digest_valid = 1'b1;
        if (digest_ready) begin
          cmd.out_step = 1'b1;
          if (status.out_last) begin
            cmd.msg_clear = 1'b1;
            state_next    = s256sh_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = s256sh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream, eight digest words out.
// A byte is taken each cycle while a block fills; its 64th byte starts a
// compression (work load, 64 rounds on one round unit, chain update). Message
// end: pad bytes one per cycle up to the length field, then the length, a
// compression per block left, then eight word transfers. Reset: initial hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  msg_valid,
  output logic                       msg_ready,
  input  wire s256sh_pkg::in_item_t  msg_item,
  output logic                       digest_valid,
  input  wire logic                  digest_ready,
  output s256sh_pkg::out_item_t      digest_item
);

  // The controller decides what happens in each cycle and the datapath holds
  // all message state. They talk only through the command and status structs.
  //
  // Message bytes are written into a sixteen-word block buffer at the fill
  // position. When the buffer is full, the controller loads the round
  // registers from the chaining hash, runs the 64 rounds one per cycle while
  // the buffer shifts as the message schedule window, and then adds the round
  // registers back into the chaining hash.
  //
  // Padding is written by the same byte path: the 0x80 mark at the fill
  // position and zeros after it, up to the last byte before the length field.
  // When the mark lands past that point, the block is zero filled to its end,
  // compressed, and a new block is zero filled before the length goes in.
  // The length is written as the last two words of the block.
  //
  // After the final compression the eight chaining words are offered one per
  // transfer, H0 first. The last transfer restores the initial hash and
  // clears the byte and bit counts, so the next message starts clean. No new
  // input transfer is taken while a block is compressed or a digest drains.

  s256sh_pkg::dp_cmd_t    cmd;
  s256sh_pkg::dp_status_t status;

  s256sh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_item     (msg_item),
    .digest_ready (digest_ready),
    .status       (status),
    .msg_ready    (msg_ready),
    .digest_valid (digest_valid),
    .cmd          (cmd)
  );

  s256sh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (msg_item.data_byte),
    .status    (status),
    .out_item  (digest_item)
  );

endmodule

`default_nettype wire

[bench/sha256_stream_hasher_tb.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Streams byte messages into the SHA-256 hasher and checks every digest word
// against a behavioral SHA-256 kept in the bench. The tests cover the special
// messages, block-boundary lengths, back-to-back traffic, a long output stall
// and randomized traffic, with random gaps on the input and stalls on output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  // The bench keeps its own copy of the FIPS 180-4 constants so that a bad
  // table in the design cannot hide behind a shared one.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int RANDOM_ITEMS = 30;
  localparam int RANDOM_MSGS  = 3;
  // Worst case after the last expected word: pad bytes, length, two blocks.
  localparam int SETTLE_CYCLES = 300;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  msg_valid    = 1'b0;
  logic                  msg_ready;
  s256sh_pkg::in_item_t  msg_item     = '0;
  logic                  digest_valid;
  logic                  digest_ready = 1'b0;
  s256sh_pkg::out_item_t digest_item;

  sha256_stream_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg_item     (msg_item),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_item  (digest_item)
  );

  // Hash state of the message in flight, as seen from the accepted transfers.
  logic [31:0] chain [8];
  logic [31:0] msg_block [16];
  logic [5:0]  fill_bytes;
  logic [63:0] bit_total;

  s256sh_pkg::out_item_t pending_words [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int msgs_sent      = 0;

  // Traffic shaping knobs, changed by the tests.
  int gap_max     = 0;
  int burst_left  = 0;
  int ready_pct   = 100;
  int hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void put_byte(int pos, logic [7:0] b);
    msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++) w[r] = msg_block[r];
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
    {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  // Applies one accepted transfer to the hash state and queues the eight
  // digest words when it ends a message. The bit count wraps at 64 bits,
  // which no simulated message comes near.
  function automatic void absorb_item(s256sh_pkg::in_item_t it);
    s256sh_pkg::out_item_t word;
    if (it.byte_valid) begin
      put_byte(fill_bytes, it.data_byte);
      bit_total  += 64'd8;
      fill_bytes += 6'd1;
      if (fill_bytes == 6'd0) compress_msg_block();
    end
    if (!it.msg_last) return;
    put_byte(fill_bytes, 8'h80);
    for (int p = int'(fill_bytes) + 1; p < 64; p++) put_byte(p, 8'h00);
    // A tail too long for the length field spills into an extra block.
    if (fill_bytes > 6'd55) begin
      compress_msg_block();
      msg_block = '{default: '0};
    end
    msg_block[14] = bit_total[63:32];
    msg_block[15] = bit_total[31:0];
    compress_msg_block();
    for (int k = 0; k < 8; k++) begin
      word.digest_word = chain[k];
      word.word_index  = 3'(k);
      word.word_last   = (k == 7);
      pending_words.push_back(word);
    end
    chain      = SHA_IV;
    fill_bytes = '0;
    bit_total  = '0;
  endfunction

  // Offers one item and waits for its transfer. Gaps fall between bursts;
  // valid stays up from one item to the next inside a burst.
  task automatic send_item(input s256sh_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        msg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    msg_valid <= 1'b1;
    msg_item  <= it;
    do @(posedge clk); while (!msg_ready);
    absorb_item(it);
    if (it.byte_valid || it.msg_last) items_sent++;
  endtask

  // Sends a message of random bytes. It ends either on its last byte or with
  // a separate end item that carries no byte; noise items carry neither flag.
  task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
    s256sh_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        it = '{data_byte: 8'($urandom), byte_valid: 1'b0, msg_last: 1'b0};
        send_item(it);
      end
      it.data_byte  = 8'($urandom);
      it.byte_valid = 1'b1;
      it.msg_last   = end_on_byte && (i == len - 1);
      send_item(it);
    end
    if (!end_on_byte || len == 0) begin
      it = '{data_byte: 8'($urandom), byte_valid: 1'b0, msg_last: 1'b1};
      send_item(it);
    end
    msgs_sent++;
  endtask

  // Drops valid and waits until every queued digest word has come out.
  task automatic wait_for_digests();
    msg_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic test_special_messages();
    gap_max   = 3;
    ready_pct = 70;
    send_item(s256sh_pkg::in_item_t'{8'h00, 1'b0, 1'b1});   // empty message
    send_item(s256sh_pkg::in_item_t'{8'hff, 1'b0, 1'b0});   // neither flag: ignored
    send_item(s256sh_pkg::in_item_t'{8'h61, 1'b1, 1'b0});   // "abc", end on last byte
    send_item(s256sh_pkg::in_item_t'{8'h62, 1'b1, 1'b0});
    send_item(s256sh_pkg::in_item_t'{8'h63, 1'b1, 1'b1});
    send_item(s256sh_pkg::in_item_t'{8'h00, 1'b1, 1'b0});
    send_item(s256sh_pkg::in_item_t'{8'hff, 1'b1, 1'b0});
    send_item(s256sh_pkg::in_item_t'{8'ha5, 1'b0, 1'b0});
    send_item(s256sh_pkg::in_item_t'{8'h80, 1'b1, 1'b0});
    send_item(s256sh_pkg::in_item_t'{8'h5a, 1'b0, 1'b1});   // end alone, byte ignored
    send_item(s256sh_pkg::in_item_t'{8'hff, 1'b1, 1'b1});   // one-byte messages in a row
    send_item(s256sh_pkg::in_item_t'{8'h00, 1'b1, 1'b1});
    wait_for_digests();
  endtask

  // Lengths around the 55-byte pad limit and the 64-byte block edge.
  task automatic test_block_boundaries();
    int lens [3] = '{55, 56, 64};
    bit on_byte [3] = '{1'b1, 1'b0, 1'b1};
    gap_max   = 2;
    ready_pct = 80;
    foreach (lens[i]) send_message(lens[i], on_byte[i], 0);
    wait_for_digests();
  endtask

  // Short messages with no gaps and no stalls, so a new message starts right
  // behind the digest of the last one and must see a fresh initial hash.
  task automatic test_back_to_back();
    gap_max   = 0;
    ready_pct = 100;
    for (int i = 0; i < 6; i++) send_message(i, 1'($urandom_range(0, 1)), 0);
    wait_for_digests();
  endtask

  // The receiver holds off long enough that the hasher backs up to its
  // input while the sender keeps offering messages.
  task automatic test_output_hold();
    gap_max     = 0;
    hold_cycles = 600;
    for (int i = 0; i < 4; i++) send_message($urandom_range(1, 10), 1'b1, 0);
    ready_pct = 60;
    wait_for_digests();
  endtask

  task automatic test_random_traffic();
    int start_items, start_msgs, pick, len;
    start_items = items_sent;
    start_msgs  = msgs_sent;
    while (items_sent - start_items < RANDOM_ITEMS || msgs_sent - start_msgs < RANDOM_MSGS)
    begin
      gap_max   = $urandom_range(0, 2) * 3;
      ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(30, 90);
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(0, 12);
      else           len = $urandom_range(50, 70);
      send_message(len, 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 1) == 1) ? 10 : 0);
      if ($urandom_range(0, 3) == 0) wait_for_digests();
    end
    wait_for_digests();
  endtask

  // Receiver: runs of random length at a level drawn from ready_pct, or a
  // long hold-off when a test asks for one.
  initial begin : receiver
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        digest_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        run = 0;
      end else if (run != 0) begin
        run--;
      end else begin
        run = $urandom_range(0, 9);
        digest_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Every digest transfer is compared with the oldest queued word.
  always @(posedge clk) begin
    s256sh_pkg::out_item_t want;
    if (!rst && digest_valid && digest_ready) begin
      if (pending_words.size() == 0) begin
        $error("digest_word: none expected, actual %h", digest_item.digest_word);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (digest_item.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word,
                 digest_item.digest_word);
          mismatch_count++;
        end
        if (digest_item.word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index,
                 digest_item.word_index);
          mismatch_count++;
        end
        if (digest_item.word_last !== want.word_last) begin
          $error("word_last: expected %b, actual %b", want.word_last,
                 digest_item.word_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** sha256_stream_hasher: FAILED **");
    $finish;
  end

  initial begin
    chain      = SHA_IV;
    msg_block  = '{default: '0};
    fill_bytes = '0;
    bit_total  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_special_messages();
    test_block_boundaries();
    test_back_to_back();
    test_output_hold();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("digest_word: %0d expected words never arrived", pending_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end

endmodule
